FILE: rtl/core/pbz_pkg.sv
// pbz_pkg: types, constants and command structs shared by the bezier evaluator
`timescale 1ns / 1ps
package pbz_pkg;

  localparam int MaxSegments = 16;
  localparam int SlotW       = 4;
  localparam int CountW      = 5;
  localparam int DataW       = 32;
  localparam int TW          = 17;
  localparam int DivSteps    = 16;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BELOW = 3'd1;
  localparam logic [2:0] ST_ABOVE = 3'd2;
  localparam logic [2:0] ST_ZERO  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  typedef struct packed {
    logic              operation;
    logic [SlotW-1:0]  slot;
    logic signed [DataW-1:0] query_x;
    logic signed [DataW-1:0] seg_start_x;
    logic signed [DataW-1:0] seg_start_y;
    logic signed [DataW-1:0] seg_ctrl_a_y;
    logic signed [DataW-1:0] seg_ctrl_b_y;
    logic signed [DataW-1:0] seg_end_x;
    logic signed [DataW-1:0] seg_end_y;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] curve_y;
    logic [SlotW-1:0]        found_segment;
    logic [2:0]              status;
  } out_item_t;

  // lerp stage selector: which operands feed the shared interpolator
  typedef enum logic [2:0] {
    LS_A = 3'd0, LS_B = 3'd1, LS_C = 3'd2, LS_D = 3'd3, LS_E = 3'd4, LS_F = 3'd5
  } lerp_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;       // capture input item
    logic       write_tab;  // store segment
    logic       rd_first;   // read entry 0 and entry n-1
    logic       rd_mid;     // read entry at mid
    logic       srch_step;  // update lo/hi from the compare
    logic       rd_lo;      // read entry lo
    logic       div_init;
    logic       div_step;
    logic       lerp_mul;   // register the product
    logic       lerp_fin;   // accumulate the lerp result
    lerp_sel_t  lsel;
    logic       res_write;  // write done
    logic       res_empty;
    logic       res_zero;
    logic       res_eval;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_eval;
    logic empty;
    logic search_done;
    logic zero_width;
  } sts_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [DataW+1:0] v);
    if (v > $signed({3'b000, {(DataW-1){1'b1}}})) return {1'b0, {(DataW-1){1'b1}}};
    if (v < $signed({3'b111, {(DataW-1){1'b0}}})) return {1'b1, {(DataW-1){1'b0}}};
    return v[DataW-1:0];
  endfunction

endpackage

FILE: rtl/core/pbz_ctrl.sv
// pbz_ctrl: sequencing state machine for the bezier evaluator
`timescale 1ns / 1ps
module pbz_ctrl import pbz_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic res_busy,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DISP  = 9'b000000010,
    S_FIRST = 9'b000000100,
    S_MID   = 9'b000001000,
    S_CMP   = 9'b000010000,
    S_LO    = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_MUL   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  lerp_sel_t lsel_r, lsel_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands; a result is held back while the output register is full
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    lsel_nxt  = lsel_r;
    cmd       = '0;
    cmd.lsel  = lsel_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (!sts.is_eval) begin
          if (!res_busy) begin
            cmd.write_tab = 1'b1;
            cmd.res_write = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (sts.empty) begin
          if (!res_busy) begin
            cmd.res_empty = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.rd_first = 1'b1;
          state_nxt = S_FIRST;
        end
      end
      // domain bounds and search limits settle here
      S_FIRST: state_nxt = S_MID;
      S_MID: begin
        if (sts.search_done) begin
          cmd.rd_lo = 1'b1;
          state_nxt = S_LO;
        end else begin
          cmd.rd_mid = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.srch_step = 1'b1;
        state_nxt = S_MID;
      end
      S_LO: begin
        if (sts.zero_width) begin
          if (!res_busy) begin
            cmd.res_zero = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.div_init = 1'b1;
          cnt_nxt = 5'(DivSteps);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          lsel_nxt = LS_A;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.lerp_mul = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (lsel_r == LS_F) begin
          if (!res_busy) begin
            cmd.lerp_fin = 1'b1;
            cmd.res_eval = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.lerp_fin = 1'b1;
          lsel_nxt = lerp_sel_t'(lsel_r + 3'd1);
          state_nxt = S_MUL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      lsel_r  <= LS_A;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      lsel_r  <= lsel_nxt;
    end
  end

endmodule

FILE: rtl/core/pbz_dp.sv
// pbz_dp: segment tables, search, divider and shared interpolator
`timescale 1ns / 1ps
module pbz_dp import pbz_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  logic [CountW-1:0] seg_count,
  input  cmd_t       cmd,
  output sts_t       sts,
  output logic       res_load,
  output out_item_t  res_item
);

  // segment tables: six fields in one row
  typedef struct packed {
    logic signed [DataW-1:0] sx, sy, ay, by, ex, ey;
  } seg_t;

  seg_t tab [MaxSegments];

  in_item_t item_r;
  logic [CountW-1:0] n_r;
  logic [CountW-1:0] lo_r, hi_r;
  logic [CountW-1:0] mid;
  logic [2:0] stat_r;
  seg_t rd_r;
  logic signed [DataW-1:0] sx0_r, exn_r;
  logic rd_first_r;

  // divider state: restoring, one quotient bit per step
  logic [DataW:0]   den_r;
  logic [DataW+1:0] rem_r;
  logic [TW-1:0]    t_r;

  // interpolator registers
  logic signed [DataW+1:0] pa_r, pb_r, pc_r, pd_r, pe_r;
  logic signed [DataW+1:0] la, lb;
  logic signed [DataW+TW+2:0] prod_r;
  logic signed [DataW+1:0] lres;

  logic signed [DataW:0] diff_x;
  logic signed [DataW:0] width_x;

  assign mid = CountW'((lo_r + hi_r) >> 1);

  assign sts.is_eval     = item_r.operation == OP_EVAL;
  assign sts.empty       = n_r == '0;
  assign sts.search_done = rd_first_r ? 1'b0 : (hi_r - lo_r <= CountW'(1));
  assign sts.zero_width  = rd_r.ex <= rd_r.sx;

  assign diff_x  = 33'(item_r.query_x) - 33'(rd_r.sx);
  assign width_x = 33'(rd_r.ex) - 33'(rd_r.sx);

  // table write and registered reads
  always_ff @(posedge clk) begin
    if (cmd.write_tab)
      tab[item_r.slot] <= '{item_r.seg_start_x, item_r.seg_start_y, item_r.seg_ctrl_a_y,
                            item_r.seg_ctrl_b_y, item_r.seg_end_x, item_r.seg_end_y};
    if (cmd.rd_mid)
      rd_r <= tab[mid[SlotW-1:0]];
    else if (cmd.rd_lo)
      rd_r <= tab[lo_r[SlotW-1:0]];
    if (cmd.rd_first) begin
      sx0_r  <= tab[0].sx;
      exn_r  <= tab[SlotW'(n_r - CountW'(1))].ex;
    end
  end

  // capture, search bounds and domain flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_first_r <= 1'b0;
    end else begin
      rd_first_r <= cmd.rd_first;
    end
    if (cmd.load) begin
      item_r <= in_item;
      n_r    <= (seg_count > CountW'(MaxSegments)) ? CountW'(MaxSegments) : seg_count;
      stat_r <= ST_OK;
    end
    if (rd_first_r) begin
      lo_r <= '0;
      hi_r <= n_r;
      if (item_r.query_x < sx0_r) begin
        stat_r <= ST_BELOW; hi_r <= CountW'(1);
      end else if (item_r.query_x > exn_r) begin
        stat_r <= ST_ABOVE; lo_r <= n_r - CountW'(1); hi_r <= n_r;
      end
    end else if (cmd.srch_step) begin
      if (rd_r.sx <= item_r.query_x) lo_r <= mid;
      else hi_r <= mid;
    end
  end

  // divider: t = floor(num*65536/den) clamped, numerator below den
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      den_r <= width_x;
      rem_r <= {2'b00, diff_x[DataW-1:0]};
      t_r   <= (diff_x <= 0) ? '0 : (diff_x >= width_x) ? TW'(65536) : '0;
    end else if (cmd.div_step) begin
      if (!(diff_x <= 0) && !(diff_x >= width_x)) begin
        if ($signed({rem_r[DataW:0], 1'b0}) >= $signed({1'b0, den_r})) begin
          rem_r <= {rem_r[DataW:0], 1'b0} - {1'b0, den_r};
          t_r   <= {t_r[TW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[DataW:0], 1'b0};
          t_r   <= {t_r[TW-2:0], 1'b0};
        end
      end
    end
  end

  // operand select for the shared lerp
  always_comb begin
    case (cmd.lsel)
      LS_A:    begin la = 34'(rd_r.sy); lb = 34'(rd_r.ay); end
      LS_B:    begin la = 34'(rd_r.ay); lb = 34'(rd_r.by); end
      LS_C:    begin la = 34'(rd_r.by); lb = 34'(rd_r.ey); end
      LS_D:    begin la = pa_r; lb = pb_r; end
      LS_E:    begin la = pb_r; lb = pc_r; end
      LS_F:    begin la = pd_r; lb = pe_r; end
      default: begin la = pa_r; lb = pb_r; end
    endcase
  end

  assign lres = la + 34'((prod_r + 52'sd32768) >>> 16);

  // the last stage feeds the result directly
  always_ff @(posedge clk) begin
    if (cmd.lerp_mul)
      prod_r <= (lb - la) * $signed({1'b0, t_r});
    if (cmd.lerp_fin) begin
      case (cmd.lsel)
        LS_A:    pa_r <= lres;
        LS_B:    pb_r <= lres;
        LS_C:    pc_r <= lres;
        LS_D:    pd_r <= lres;
        LS_E:    pe_r <= lres;
        default: ;
      endcase
    end
  end

  // result assembly
  assign res_load = cmd.res_write || cmd.res_empty || cmd.res_zero || cmd.res_eval;
  always_comb begin
    res_item = '0;
    if (cmd.res_empty) begin
      res_item.status = ST_EMPTY;
    end else if (cmd.res_zero) begin
      res_item.curve_y = rd_r.sy;
      res_item.found_segment = lo_r[SlotW-1:0];
      res_item.status = ST_ZERO;
    end else if (cmd.res_eval) begin
      res_item.curve_y = sat32(lres);
      res_item.found_segment = lo_r[SlotW-1:0];
      res_item.status = stat_r;
    end
  end

endmodule

FILE: rtl/core/piecewise_bezier_curve_eval_unit.sv
// piecewise_bezier_curve_eval_unit: top level of the piecewise cubic bezier evaluator
//
// Input items arrive on in_valid/in_ready with payload in_item. A write item
// (operation 0) stores one segment in the table; an evaluate item (operation 1)
// searches the first segment_count entries for the segment spanning query_x,
// forms t by a 16-step restoring divider and blends the four y values by
// de Casteljau through one shared multiplier.
// Each item yields one result item on out_valid/out_ready through an output
// register; the next item is taken as soon as the controller is idle again.
// A write or an empty curve is answered straight from dispatch, a zero-width
// segment right after the search; an evaluate adds the 16 divider steps and the
// six multiply/accumulate passes, with at most four search steps at 16 segments.
// One item is in work at a time. The segment count is to be written on
// cfg_we/cfg_data only while idle; the block itself does not enforce this.
// Reset (rst_n low, synchronous) clears the count, the controller and the
// output valid flag; the tables hold nothing until written.
// When the receiver stalls, the result stays in out_item and the controller
// holds the next result back until the register has been taken.
`timescale 1ns / 1ps
module piecewise_bezier_curve_eval_unit import pbz_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [CountW-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic res_load;
  logic res_busy;
  out_item_t res_item;
  logic [CountW-1:0] count_r;
  logic out_valid_r;
  out_item_t out_item_r;

  // segment count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we) begin
      count_r <= cfg_data;
    end
  end

  // output register stays full this cycle
  assign res_busy = out_valid_r && !out_ready;

  pbz_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .res_busy(res_busy), .sts(sts), .cmd(cmd)
  );

  pbz_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .seg_count(count_r),
    .cmd(cmd), .sts(sts), .res_load(res_load), .res_item(res_item)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_load) out_item_r <= res_item;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> !out_valid || out_ready) else $error("result overwrote pending result");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.status <= ST_EMPTY) else $error("bad status code");
`endif

endmodule

FILE: test/testbench.sv
// testbench: self-checking bench for the piecewise bezier curve evaluator
`timescale 1ns / 1ps
module testbench;
  import pbz_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  logic      cfg_we;
  logic [CountW-1:0] cfg_data;

  piecewise_bezier_curve_eval_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // own copy of the segment table and count
  logic signed [31:0] tab_sx [MaxSegments];
  logic signed [31:0] tab_sy [MaxSegments];
  logic signed [31:0] tab_ca [MaxSegments];
  logic signed [31:0] tab_cb [MaxSegments];
  logic signed [31:0] tab_ex [MaxSegments];
  logic signed [31:0] tab_ey [MaxSegments];
  logic [CountW-1:0]  seg_count;

  out_item_t pending_curve[$];
  int  errors;
  int  n_results;
  int  n_eval;
  int  send_idle;
  int  recv_idle;

  // one directed row: item plus optional typed-in result
  typedef struct {
    in_item_t  item;
    logic      has_exp;
    out_item_t exp_res;
  } row_t;
  row_t rows[$];

  // linear step, rounding half up
  function automatic longint lerp_q16(longint a, longint b, longint t);
    longint v;
    v = (b - a) * t + 32768;
    return a + (v >>> 16);
  endfunction

  function automatic logic signed [31:0] sat_q16(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // expected result of one item, updating the table on writes
  function automatic out_item_t predict_curve(in_item_t it);
    out_item_t r;
    int n, lo, hi, mid;
    longint x, sx, ex, t, p0, p1, p2, p3, a, b, c, d, e;
    r = '0;
    if (it.operation == OP_WRITE) begin
      tab_sx[it.slot] = it.seg_start_x;
      tab_sy[it.slot] = it.seg_start_y;
      tab_ca[it.slot] = it.seg_ctrl_a_y;
      tab_cb[it.slot] = it.seg_ctrl_b_y;
      tab_ex[it.slot] = it.seg_end_x;
      tab_ey[it.slot] = it.seg_end_y;
      return r;
    end
    n = (seg_count > MaxSegments) ? MaxSegments : seg_count;
    if (n == 0) begin
      r.status = ST_EMPTY;
      return r;
    end
    x = it.query_x;
    lo = 0;
    r.status = ST_OK;
    if (x < longint'(tab_sx[0])) begin
      r.status = ST_BELOW;
    end else if (x > longint'(tab_ex[n-1])) begin
      lo = n - 1;
      r.status = ST_ABOVE;
    end else begin
      hi = n;
      while (hi - lo > 1) begin
        mid = (lo + hi) / 2;
        if (longint'(tab_sx[mid]) <= x) lo = mid;
        else hi = mid;
      end
    end
    sx = tab_sx[lo];
    ex = tab_ex[lo];
    p0 = tab_sy[lo];
    r.found_segment = lo[3:0];
    if (ex <= sx) begin
      r.curve_y = sat_q16(p0);
      r.status = ST_ZERO;
      return r;
    end
    if (x <= sx) t = 0;
    else if (x >= ex) t = 65536;
    else begin
      t = ((x - sx) << 16) / (ex - sx);
      if (t > 65536) t = 65536;
    end
    p1 = tab_ca[lo];
    p2 = tab_cb[lo];
    p3 = tab_ey[lo];
    a = lerp_q16(p0, p1, t);
    b = lerp_q16(p1, p2, t);
    c = lerp_q16(p2, p3, t);
    d = lerp_q16(a, b, t);
    e = lerp_q16(b, c, t);
    r.curve_y = sat_q16(lerp_q16(d, e, t));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_curve.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        w = pending_curve.pop_front();
        if (out_item.curve_y !== w.curve_y)
          report_mismatch("curve_y", out_item.curve_y, w.curve_y);
        if (out_item.found_segment !== w.found_segment)
          report_mismatch("found_segment", out_item.found_segment, w.found_segment);
        if (out_item.status !== w.status)
          report_mismatch("status", out_item.status, w.status);
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // send one item, predicting on acceptance
  task automatic send_item(input in_item_t it, input logic has_exp, input out_item_t ex);
    out_item_t p;
    logic acc;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    // in_ready only moves at the rising edge, so its value mid-cycle holds at the edge
    acc = 1'b0;
    while (!acc) begin
      @(negedge clk);
      acc = in_ready;
      @(posedge clk);
    end
    p = predict_curve(it);
    if (it.operation == OP_EVAL) n_eval++;
    if (has_exp && p !== ex) report_mismatch("table row vs predictor", p, ex);
    pending_curve.push_back(p);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_curve.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_count(input logic [CountW-1:0] v);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    seg_count = v;
  endtask

  function automatic in_item_t mk_write(int s, int sx, int sy, int ca, int cb, int ex, int ey);
    in_item_t it;
    it = '0;
    it.operation = OP_WRITE;
    it.slot = s[3:0];
    it.query_x = $urandom;
    it.seg_start_x = sx; it.seg_start_y = sy;
    it.seg_ctrl_a_y = ca; it.seg_ctrl_b_y = cb;
    it.seg_end_x = ex; it.seg_end_y = ey;
    return it;
  endfunction

  function automatic in_item_t mk_eval(int x);
    in_item_t it;
    it = '0;
    it.operation = OP_EVAL;
    it.slot = SlotW'($urandom);
    it.query_x = x;
    it.seg_start_x = $urandom; it.seg_start_y = $urandom;
    it.seg_end_x = $urandom;
    return it;
  endfunction

  function automatic void add_row(in_item_t it, logic h, out_item_t e);
    row_t r;
    r.item = it; r.has_exp = h; r.exp_res = e;
    rows.push_back(r);
  endfunction

  // random sorted curve of k segments, with occasional zero widths and gaps
  task automatic load_random_curve(input int k, input logic full_range);
    int x0, w, i;
    x0 = full_range ? -32'sd2000000000 : -int'($urandom_range(500000));
    for (i = 0; i < k; i++) begin
      w = full_range ? int'($urandom_range(250000000)) : int'($urandom_range(200000));
      if ($urandom_range(15) == 0) w = 0;
      send_item(mk_write(i, x0, $urandom, $urandom, $urandom, x0 + w, $urandom), 1'b0, '0);
      x0 = x0 + w + (($urandom_range(3) == 0) ? int'($urandom_range(5000)) : 0);
    end
  endtask

  function automatic int pick_query(int k);
    int s;
    if (k == 0 || $urandom_range(9) == 0) return $urandom;
    s = $urandom_range(k - 1);
    case ($urandom_range(3))
      0: return tab_sx[s];
      1: return tab_ex[s];
      default: return tab_sx[s] + int'($urandom_range(200000)) - 1000;
    endcase
  endfunction

  initial begin
    out_item_t e;
    int i, k, ph, cnt;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    seg_count = '0;
    errors = 0; n_results = 0; n_eval = 0;
    send_idle = 0; recv_idle = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: empty curve after reset, then extremes
    e = '0; e.status = ST_EMPTY;
    add_row(mk_eval(32'sh7fffffff), 1'b1, e);
    add_row(mk_eval(32'sh80000000), 1'b1, e);
    e = '0;
    add_row(mk_write(0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                     32'sh00010000, 32'sh7fffffff), 1'b1, e);
    add_row(mk_write(1, 32'sh00010000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                     32'sh00010000, 32'sh7fffffff), 1'b1, e);
    add_row(mk_write(2, 32'sh00020000, -32'sd65536, 32'sh80000000, 32'sh7fffffff,
                     32'sh7fffffff, 32'sh80000000), 1'b1, e);
    add_row(mk_write(15, 32'sh80000000, 1, 2, 3, 32'sh7fffffff, 4), 1'b1, e);
    foreach (rows[j]) send_item(rows[j].item, rows[j].has_exp, rows[j].exp_res);
    rows.delete();

    write_count(5'd3);
    e = '0; e.status = ST_BELOW; e.curve_y = 32'sh7fffffff;
    add_row(mk_eval(-1), 1'b1, e);
    e = '0; e.status = ST_BELOW; e.curve_y = 32'sh7fffffff;
    add_row(mk_eval(32'sh80000000), 1'b1, e);
    e = '0; e.found_segment = 4'd1; e.status = ST_ZERO; e.curve_y = 32'sh80000000;
    add_row(mk_eval(32'sh00010000), 1'b1, e);
    e = '0; e.found_segment = 4'd2; e.curve_y = -32'sd65536;
    add_row(mk_eval(32'sh00020000), 1'b1, e);
    e = '0; e.found_segment = 4'd2; e.curve_y = 32'sh80000000;
    add_row(mk_eval(32'sh7fffffff), 1'b1, e);
    add_row(mk_eval(32'sh00008000), 1'b0, e);
    add_row(mk_eval(32'sh12345678), 1'b0, e);
    foreach (rows[j]) send_item(rows[j].item, rows[j].has_exp, rows[j].exp_res);
    rows.delete();

    // above domain: shrink last segment
    send_item(mk_write(2, 32'sh00020000, 10, 20, 30, 32'sh00030000, 40), 1'b0, '0);
    e = '0; e.found_segment = 4'd2; e.status = ST_ABOVE; e.curve_y = 40;
    send_item(mk_eval(32'sh7fffffff), 1'b1, e);

    // count above table size, then the full table
    for (i = 0; i < MaxSegments; i++)
      send_item(mk_write(i, i * 65536, i, i, i, i * 65536 + 65536, i), 1'b0, '0);
    write_count(5'd31);
    send_item(mk_eval(32'sh000f8000), 1'b0, '0);
    write_count(5'd16);
    send_item(mk_eval(32'sh0000c000), 1'b0, '0);

    // random phases: idling profile, then curve settings
    for (ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 18 : (ph == 1) ? 59 : 0;
      recv_idle = (ph == 0) ? 59 : (ph == 1) ? 18 : 0;
      for (cnt = 0; cnt < 8; cnt++) begin
        k = (cnt == 0) ? 16 : (cnt == 1) ? 1 : int'($urandom_range(1, 16));
        load_random_curve(k, cnt[0]);
        // unsorted table occasionally
        if (cnt == 3)
          for (i = 0; i < k; i++)
            if ($urandom_range(3) == 0)
              send_item(mk_write(i, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom), 1'b0, '0);
        write_count((cnt == 7) ? 5'd0 : k[CountW-1:0]);
        for (i = 0; i < 60; i++) begin
          if (i == 30) drain_results();
          if ($urandom_range(9) == 0)
            send_item(mk_write((k < MaxSegments) ? k + int'($urandom_range(15 - k))
                                                 : int'($urandom_range(15)),
                               $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom), 1'b0, '0);
          else
            send_item(mk_eval(pick_query((cnt == 7) ? 0 : k)), 1'b0, '0);
        end
      end
    end

    drain_results();
    $display("covered %0d results, %0d evaluations, over empty, single, full and",
             n_results, n_eval);
    $display("oversized curves with three idling profiles");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // timeout
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
